FILE: rtl/ott_pkg.sv
// Shared types, widths and helpers for the ordered timer table.
// No dependencies; every other file except ott_ram refers to it by scoped names.
package ott_pkg;

  localparam int NumTimers = 16;
  localparam int IdxW      = $clog2(NumTimers);
  localparam int CntW      = IdxW + 1;
  localparam int SlotW     = 4;
  localparam int CmdW      = 3;
  localparam int StatW     = 2;
  localparam int TimeW     = 48;
  localparam int PerW      = 32;

  localparam logic [TimeW-1:0] TMax = {TimeW{1'b1}};

  typedef enum logic [CmdW-1:0] {
    CMD_ADD     = 3'd0,
    CMD_CANCEL  = 3'd1,
    CMD_RESET   = 3'd2,
    CMD_REFRESH = 3'd3,
    CMD_EXPIRE  = 3'd4,
    CMD_NEXT    = 3'd5
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK         = 2'd0,
    STAT_NOT_ACTIVE = 2'd1,
    STAT_FULL       = 2'd2,
    STAT_NONE       = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_EXP_STEP,
    S_ADD_FIN,
    S_NEXT_FIN,
    S_READ,
    S_CALC,
    S_UPDATE,
    S_REPLY
  } state_e;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] out_slot;
    logic             earliest;
    logic [TimeW-1:0] wait_ms;
    logic             any_active;
    logic             last;
  } res_t;

  typedef struct packed {
    logic             we_per;
    logic             we_dl;
    logic [IdxW-1:0]  waddr;
    logic [PerW-1:0]  wper;
    logic [TimeW-1:0] wdl;
    logic [IdxW-1:0]  raddr;
  } mem_req_t;

  // start + period, clamped to the largest time value
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [PerW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {{(TimeW - PerW + 1){1'b0}}, b};
    return s[TimeW] ? TMax : s[TimeW-1:0];
  endfunction

endpackage

FILE: rtl/ott_cmd_if.sv
// Command channel: valid/ready handshake plus one command item.
// Depends on ott_pkg for field widths.
interface ott_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [ott_pkg::CmdW-1:0]   cmd;
  logic [ott_pkg::TimeW-1:0]  now_ms;
  logic [ott_pkg::SlotW-1:0]  slot;
  logic [ott_pkg::PerW-1:0]   period_ms;
  logic                       repeat_req;
  logic                       restart;

  modport source(output valid, cmd, now_ms, slot, period_ms, repeat_req, restart,
                 input ready);
  modport sink(input valid, cmd, now_ms, slot, period_ms, repeat_req, restart,
               output ready);
endinterface

FILE: rtl/ott_res_if.sv
// Result channel: valid/ready handshake plus one result item.
// Depends on ott_pkg for field widths.
interface ott_res_if;
  logic                       valid;
  logic                       ready;
  logic [ott_pkg::StatW-1:0]  status;
  logic [ott_pkg::SlotW-1:0]  out_slot;
  logic                       earliest;
  logic [ott_pkg::TimeW-1:0]  wait_ms;
  logic                       any_active;
  logic                       last;

  modport source(output valid, status, out_slot, earliest, wait_ms, any_active, last,
                 input ready);
  modport sink(input valid, status, out_slot, earliest, wait_ms, any_active, last,
               output ready);
endinterface

FILE: rtl/ott_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ott_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ott_ctrl.sv
// Command sequencer: flags, memory scans, ordering and result generation.
// Depends on ott_pkg and ott_cmd_if; drives the period and deadline RAMs.
module ott_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  ott_cmd_if.sink                   cmd_i,
  output ott_pkg::mem_req_t         mem_o,
  input  logic [ott_pkg::PerW-1:0]  per_rdata_i,
  input  logic [ott_pkg::TimeW-1:0] dl_rdata_i,
  output logic                      push_valid_o,
  output ott_pkg::res_t             rslt_o,
  input  logic                      push_ready_i
);

  localparam int N    = ott_pkg::NumTimers;
  localparam int IdxW = ott_pkg::IdxW;
  localparam int CntW = ott_pkg::CntW;

  ott_pkg::state_e state_q, state_d;

  logic [N-1:0] act_q, rep_q, taken_q, due_q;
  logic [CntW-1:0] cnt_q, due_cnt_q, emit_cnt_q;
  logic rd_vld_q, have_q, front_q, first_q;

  logic [ott_pkg::CmdW-1:0]  cmd_q;
  logic [ott_pkg::TimeW-1:0] now_q, newdl_q, bestd_q, base_q;
  logic [IdxW-1:0]           slot_q, free_q, rd_idx_q, best_q;
  logic [ott_pkg::PerW-1:0]  per_q, bestp_q, addend_q;
  logic                      repreq_q, fnow_q, chg_q;
  ott_pkg::status_e          stat_q;

  logic            accept, free_found, slot_ok, slot_live, scan_issue, scan_done;
  logic            due_hit, elig, take, front_kill, exp_last, any_act, any_exp;
  logic [IdxW-1:0] free_idx, cmd_idx;

  assign accept  = (state_q == ott_pkg::S_IDLE) && cmd_i.valid;
  assign cmd_i.ready = (state_q == ott_pkg::S_IDLE);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  assign cmd_idx   = cmd_i.slot[IdxW-1:0];
  assign slot_ok   = (32'(cmd_i.slot) < N);
  assign slot_live = slot_ok && act_q[cmd_idx];

  assign any_act = |act_q;
  // one-shot due timers leave the table, recurring ones stay
  assign any_exp = |(act_q & ~(due_q & ~rep_q));

  assign scan_issue = (state_q == ott_pkg::S_SCAN) && (cnt_q < CntW'(N));
  assign scan_done  = (cnt_q == CntW'(N)) && !rd_vld_q;

  // evaluation of the entry returned by the RAMs
  assign due_hit = act_q[rd_idx_q] && (dl_rdata_i <= now_q);
  always_comb begin
    case (cmd_q)
      ott_pkg::CMD_EXPIRE: elig = due_hit && !taken_q[rd_idx_q];
      ott_pkg::CMD_NEXT:   elig = act_q[rd_idx_q];
      default:             elig = 1'b0;
    endcase
  end
  assign take       = rd_vld_q && elig && (!have_q || (dl_rdata_i < bestd_q));
  assign front_kill = rd_vld_q && act_q[rd_idx_q] &&
                      ((dl_rdata_i < newdl_q) ||
                       ((dl_rdata_i == newdl_q) && (rd_idx_q < free_q)));
  assign exp_last   = ((emit_cnt_q + CntW'(1)) == due_cnt_q);

  always_comb begin
    state_d      = state_q;
    push_valid_o = 1'b0;
    rslt_o       = '0;
    rslt_o.any_active = any_act;
    rslt_o.last       = 1'b1;
    mem_o        = '0;
    mem_o.raddr  = slot_q;
    case (state_q)
      ott_pkg::S_IDLE: begin
        if (cmd_i.valid) begin
          case (cmd_i.cmd)
            ott_pkg::CMD_ADD:     state_d = free_found ? ott_pkg::S_SCAN : ott_pkg::S_REPLY;
            ott_pkg::CMD_RESET,
            ott_pkg::CMD_REFRESH: state_d = slot_live ? ott_pkg::S_READ : ott_pkg::S_REPLY;
            ott_pkg::CMD_EXPIRE,
            ott_pkg::CMD_NEXT:    state_d = ott_pkg::S_SCAN;
            default:              state_d = ott_pkg::S_REPLY;
          endcase
        end
      end
      ott_pkg::S_SCAN: begin
        mem_o.raddr = cnt_q[IdxW-1:0];
        if (scan_done) begin
          case (cmd_q)
            ott_pkg::CMD_ADD:    state_d = ott_pkg::S_ADD_FIN;
            ott_pkg::CMD_EXPIRE: state_d = ott_pkg::S_EXP_STEP;
            default:             state_d = ott_pkg::S_NEXT_FIN;
          endcase
        end
      end
      ott_pkg::S_EXP_STEP: begin
        push_valid_o = 1'b1;
        if (!have_q) begin
          rslt_o.status = ott_pkg::STAT_NONE;
        end else begin
          rslt_o.out_slot   = ott_pkg::SlotW'(best_q);
          rslt_o.last       = exp_last;
          rslt_o.any_active = any_exp;
          mem_o.waddr = best_q;
          mem_o.wdl   = ott_pkg::sat_add(now_q, bestp_q);
          mem_o.we_dl = push_ready_i && rep_q[best_q];
        end
        if (push_ready_i) begin
          state_d = (!have_q || exp_last) ? ott_pkg::S_IDLE : ott_pkg::S_SCAN;
        end
      end
      ott_pkg::S_ADD_FIN: begin
        push_valid_o      = 1'b1;
        rslt_o.out_slot   = ott_pkg::SlotW'(free_q);
        rslt_o.earliest   = front_q;
        rslt_o.any_active = 1'b1;
        mem_o.waddr  = free_q;
        mem_o.wper   = per_q;
        mem_o.wdl    = newdl_q;
        mem_o.we_per = push_ready_i;
        mem_o.we_dl  = push_ready_i;
        if (push_ready_i) begin
          state_d = ott_pkg::S_IDLE;
        end
      end
      ott_pkg::S_NEXT_FIN: begin
        push_valid_o = 1'b1;
        if (have_q && (bestd_q >= now_q)) begin
          rslt_o.wait_ms = bestd_q - now_q;
        end
        if (push_ready_i) begin
          state_d = ott_pkg::S_IDLE;
        end
      end
      ott_pkg::S_READ: state_d = ott_pkg::S_CALC;
      ott_pkg::S_CALC: state_d = ott_pkg::S_UPDATE;
      ott_pkg::S_UPDATE: begin
        push_valid_o = 1'b1;
        mem_o.waddr  = slot_q;
        mem_o.wper   = per_q;
        mem_o.wdl    = ott_pkg::sat_add(base_q, addend_q);
        mem_o.we_dl  = push_ready_i && chg_q;
        mem_o.we_per = push_ready_i && chg_q && (cmd_q == ott_pkg::CMD_RESET);
        if (push_ready_i) begin
          state_d = ott_pkg::S_IDLE;
        end
      end
      ott_pkg::S_REPLY: begin
        push_valid_o  = 1'b1;
        rslt_o.status = stat_q;
        if (push_ready_i) begin
          state_d = ott_pkg::S_IDLE;
        end
      end
      default: state_d = ott_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ott_pkg::S_IDLE;
      act_q      <= '0;
      rep_q      <= '0;
      taken_q    <= '0;
      due_q      <= '0;
      cnt_q      <= '0;
      due_cnt_q  <= '0;
      emit_cnt_q <= '0;
      rd_vld_q   <= 1'b0;
      have_q     <= 1'b0;
      front_q    <= 1'b0;
      first_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= scan_issue;
      if (scan_issue) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (take) begin
        have_q <= 1'b1;
      end
      if (front_kill) begin
        front_q <= 1'b0;
      end
      // due set and count come from the first pass only
      if (rd_vld_q && first_q && (cmd_q == ott_pkg::CMD_EXPIRE)) begin
        due_q[rd_idx_q] <= due_hit;
        due_cnt_q       <= due_cnt_q + CntW'(due_hit);
      end
      case (state_q)
        ott_pkg::S_IDLE: begin
          if (accept) begin
            cnt_q      <= '0;
            have_q     <= 1'b0;
            front_q    <= 1'b1;
            taken_q    <= '0;
            due_q      <= '0;
            due_cnt_q  <= '0;
            emit_cnt_q <= '0;
            first_q    <= 1'b1;
            if ((cmd_i.cmd == ott_pkg::CMD_CANCEL) && slot_live) begin
              act_q[cmd_idx] <= 1'b0;
            end
          end
        end
        ott_pkg::S_EXP_STEP: begin
          if (push_ready_i && have_q) begin
            taken_q[best_q] <= 1'b1;
            if (!rep_q[best_q]) begin
              act_q[best_q] <= 1'b0;
            end
            emit_cnt_q <= emit_cnt_q + CntW'(1);
            first_q    <= 1'b0;
            cnt_q      <= '0;
            have_q     <= 1'b0;
          end
        end
        ott_pkg::S_ADD_FIN: begin
          if (push_ready_i) begin
            act_q[free_q] <= 1'b1;
            rep_q[free_q] <= repreq_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[IdxW-1:0];
    if (take) begin
      best_q  <= rd_idx_q;
      bestd_q <= dl_rdata_i;
      bestp_q <= per_rdata_i;
    end
    if (accept) begin
      cmd_q    <= cmd_i.cmd;
      now_q    <= cmd_i.now_ms;
      slot_q   <= cmd_idx;
      per_q    <= cmd_i.period_ms;
      repreq_q <= cmd_i.repeat_req;
      fnow_q   <= cmd_i.restart;
      newdl_q  <= ott_pkg::sat_add(cmd_i.now_ms, cmd_i.period_ms);
      free_q   <= free_idx;
      case (cmd_i.cmd)
        ott_pkg::CMD_ADD:     stat_q <= ott_pkg::STAT_FULL;
        ott_pkg::CMD_CANCEL:  stat_q <= slot_live ? ott_pkg::STAT_OK
                                                  : ott_pkg::STAT_NOT_ACTIVE;
        ott_pkg::CMD_RESET,
        ott_pkg::CMD_REFRESH: stat_q <= ott_pkg::STAT_NOT_ACTIVE;
        default:              stat_q <= ott_pkg::STAT_OK;
      endcase
    end
    // slot entry is on the RAM outputs: form start point and addend
    if (state_q == ott_pkg::S_CALC) begin
      if (cmd_q == ott_pkg::CMD_RESET) begin
        if (fnow_q) begin
          base_q <= now_q;
        end else if (dl_rdata_i >= {{(ott_pkg::TimeW - ott_pkg::PerW){1'b0}}, per_rdata_i}) begin
          base_q <= dl_rdata_i - {{(ott_pkg::TimeW - ott_pkg::PerW){1'b0}}, per_rdata_i};
        end else begin
          base_q <= '0;
        end
        addend_q <= per_q;
        chg_q    <= !((per_q == per_rdata_i) && !fnow_q);
      end else begin
        base_q   <= now_q;
        addend_q <= per_rdata_i;
        chg_q    <= 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  // read data only ever returns inside a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ott_pkg::S_SCAN))
    else $error("ott_ctrl: read data outside scan");

  // RAM writes never overlap a scan, so no forwarding is needed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ott_pkg::S_SCAN) |-> !(mem_o.we_dl || mem_o.we_per))
    else $error("ott_ctrl: RAM write during scan");

  // expire never emits more timers than were due
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ott_pkg::S_EXP_STEP) && have_q) |-> (emit_cnt_q < due_cnt_q))
    else $error("ott_ctrl: expire overrun");

  // an accepted command always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ott_pkg::S_IDLE))
    else $error("ott_ctrl: command accepted without work");
`endif

endmodule

FILE: rtl/ordered_timer_table_top.sv
// Ordered timer table: 16 timer slots, period/deadline in RAM, flags in flops.
// Cancel, errors and unknown commands reply directly; reset/refresh pass through the
// read, calc and update states; add and next make one pass over the 16 RAM entries.
// Expire makes one pass per due timer, or one pass when none is due. Next item is
// taken the cycle after the last result enters the output register.
// Reset clears all active and recurring flags; the RAMs are not cleared.
module ordered_timer_table_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ott_cmd_if.sink    cmd_i,
  ott_res_if.source  res_o
);

  ott_pkg::mem_req_t             mem_req;
  logic [ott_pkg::PerW-1:0]      per_rdata;
  logic [ott_pkg::TimeW-1:0]     dl_rdata;
  logic                          push_valid, push_ready;
  ott_pkg::res_t                 rslt, res_q;
  logic                          res_vld_q;

  // sequencer: owns the flags and drives both RAMs
  ott_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .mem_o        (mem_req),
    .per_rdata_i  (per_rdata),
    .dl_rdata_i   (dl_rdata),
    .push_valid_o (push_valid),
    .rslt_o       (rslt),
    .push_ready_i (push_ready)
  );

  // period store, written by add and reset
  ott_ram #(
    .Width (ott_pkg::PerW),
    .Depth (ott_pkg::NumTimers)
  ) u_per_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we_per),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wper),
    .raddr_i (mem_req.raddr),
    .rdata_o (per_rdata)
  );

  // deadline store, rewritten on add, reset, refresh and re-arm
  ott_ram #(
    .Width (ott_pkg::TimeW),
    .Depth (ott_pkg::NumTimers)
  ) u_dl_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we_dl),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdl),
    .raddr_i (mem_req.raddr),
    .rdata_o (dl_rdata)
  );

  // output register: hold a result until taken, refill in the same cycle
  assign push_ready = !res_vld_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (push_valid && push_ready) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid && push_ready) begin
      res_q <= rslt;
    end
  end

  assign res_o.valid      = res_vld_q;
  assign res_o.status     = res_q.status;
  assign res_o.out_slot   = res_q.out_slot;
  assign res_o.earliest   = res_q.earliest;
  assign res_o.wait_ms    = res_q.wait_ms;
  assign res_o.any_active = res_q.any_active;
  assign res_o.last       = res_q.last;

endmodule
